/* sv/scaled_glyph_and_fill_pixel_generator_assert.svh */
// ---------------------------------------------------------------------------
// Assertion macros for the scaled glyph and fill pixel generator
// Each macro places one labeled concurrent assertion that is checked on the
// rising clock edge and is held off while reset is asserted.
// ---------------------------------------------------------------------------
`ifndef SCALED_GLYPH_AND_FILL_PIXEL_GENERATOR_ASSERT_SVH
`define SCALED_GLYPH_AND_FILL_PIXEL_GENERATOR_ASSERT_SVH

// The consequent must hold in the same cycle as the antecedent.
`define SGFPG_ASSERT_SAME(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define SGFPG_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

/* sv/sgfpg_pkg.sv */
// ---------------------------------------------------------------------------
// sgfpg_pkg
// Command and result codes, job modes and the 5x7 font table of the glyph
// and fill pixel generator.
// ---------------------------------------------------------------------------
`default_nettype none

package sgfpg_pkg;

    typedef enum logic [1:0] {
        OP_DRAW = 2'd0,
        OP_FILL = 2'd1,
        OP_PULL = 2'd2
    } op_t;

    typedef enum logic [1:0] {
        KIND_WINDOW = 2'd0,
        KIND_PIXEL  = 2'd1,
        KIND_REJECT = 2'd2
    } kind_t;

    typedef enum logic [1:0] {
        MODE_IDLE = 2'd0,
        MODE_CHAR = 2'd1,
        MODE_FILL = 2'd2
    } job_mode_t;

    localparam int unsigned GLYPH_COLS  = 5;
    localparam int unsigned GLYPH_ROWS  = 7;
    localparam int unsigned CELL_COLS   = 6;
    localparam int unsigned CELL_ROWS   = 8;
    localparam int unsigned FONT_GLYPHS = 59;

    localparam logic [7:0] CHAR_SPACE    = 8'h20;
    localparam logic [7:0] CHAR_QUESTION = 8'h3F;
    localparam logic [7:0] CHAR_LOWER_A  = 8'h61;
    localparam logic [7:0] CHAR_LOWER_Z  = 8'h7A;
    localparam logic [7:0] CHAR_UPPER_Z  = 8'h5A;
    localparam logic [7:0] CASE_OFFSET   = 8'h20;
    localparam logic [5:0] GLYPH_FALLBACK = 6'd31;

    // One entry per glyph from space to Z. Element 0 is the leftmost column;
    // bit 0 of a column is the top dot.
    typedef logic [0:GLYPH_COLS-1][7:0] glyph_t;

    localparam glyph_t FONT_ROM [FONT_GLYPHS] = '{
        40'h0000000000, 40'h00005F0000, 40'h0007000700, 40'h147F147F14,
        40'h242A7F2A12, 40'h2313086462, 40'h3649552250, 40'h0005030000,
        40'h001C224100, 40'h0041221C00, 40'h14083E0814, 40'h08083E0808,
        40'h0050300000, 40'h0808080808, 40'h0060600000, 40'h2010080402,
        40'h3E5149453E, 40'h00427F4000, 40'h4261514946, 40'h2141454B31,
        40'h1814127F10, 40'h2745454539, 40'h3C4A494930, 40'h0171090503,
        40'h3649494936, 40'h064949291E, 40'h0036360000, 40'h0056360000,
        40'h0814224100, 40'h1414141414, 40'h0041221408, 40'h0201510906,
        40'h324979413E, 40'h7E1111117E, 40'h7F49494936, 40'h3E41414122,
        40'h7F4141221C, 40'h7F49494941, 40'h7F09090901, 40'h3E4149497A,
        40'h7F0808087F, 40'h00417F4100, 40'h2040413F01, 40'h7F08142241,
        40'h7F40404040, 40'h7F020C027F, 40'h7F0408107F, 40'h3E4141413E,
        40'h7F09090906, 40'h3E4151215E, 40'h7F09192946, 40'h4649494931,
        40'h01017F0101, 40'h3F4040403F, 40'h1F2040201F, 40'h3F4038403F,
        40'h6314081463, 40'h0708700807, 40'h6151494543
    };

endpackage

`default_nettype wire

/* sv/scaled_glyph_and_fill_pixel_generator.sv */
// ---------------------------------------------------------------------------
// scaled_glyph_and_fill_pixel_generator
// Character cell and filled rectangle pixel source for a display controller.
// ---------------------------------------------------------------------------
// Every transfer on the input stream is one command: draw a character, fill
// a rectangle, or pull the next pixel of the current job. The block takes one
// transfer in every cycle while its input side is ready; its result, if any,
// appears in the output register on the next cycle. The input side is ready
// whenever that register is empty or its result is taken in the same cycle,
// so a stalled output holds back the input. A draw or fill command answers
// with the address window or a reject; a pull answers with one pixel colour
// and tlast on the final pixel of the job, or with nothing when no job runs.
// Fill jobs are counted with column and row down counters, character jobs
// with glyph position and repeat counters against the 5x7 font table.
`default_nettype none

module scaled_glyph_and_fill_pixel_generator #(
    parameter int unsigned SCREEN_WIDTH  = 320,
    parameter int unsigned SCREEN_HEIGHT = 240
) (
    input  wire logic         aclk,
    input  wire logic         aresetn,

    input  wire logic         s_tvalid,
    output logic              s_tready,
    // x_pos, y_pos, rect_width, rect_height, char_code, scale_factor,
    // fore_color, back_color
    input  wire logic [111:0] s_tdata,
    // op
    input  wire logic [1:0]   s_tuser,

    output logic              m_tvalid,
    input  wire logic         m_tready,
    // col_first, col_last, row_first, row_last, pixel_color
    output logic [79:0]       m_tdata,
    // kind
    output logic [1:0]        m_tuser,
    output logic              m_tlast
);

    `include "scaled_glyph_and_fill_pixel_generator_assert.svh"

    localparam int unsigned COL_W = $clog2(SCREEN_WIDTH + 1);
    localparam int unsigned ROW_W = $clog2(SCREEN_HEIGHT + 1);
    localparam logic [16:0] SCR_W = 17'(SCREEN_WIDTH);
    localparam logic [16:0] SCR_H = 17'(SCREEN_HEIGHT);

    // Input fields.
    logic [15:0] x_pos, y_pos, rect_width, rect_height, fore_color, back_color;
    logic [7:0]  char_code, scale_factor;
    sgfpg_pkg::op_t op;

    assign x_pos        = s_tdata[15:0];
    assign y_pos        = s_tdata[31:16];
    assign rect_width   = s_tdata[47:32];
    assign rect_height  = s_tdata[63:48];
    assign char_code    = s_tdata[71:64];
    assign scale_factor = s_tdata[79:72];
    assign fore_color   = s_tdata[95:80];
    assign back_color   = s_tdata[111:96];
    assign op           = sgfpg_pkg::op_t'(s_tuser);

    logic accept;
    assign accept = s_tvalid && s_tready;

    // Job state.
    sgfpg_pkg::job_mode_t mode_reg, mode_next;
    logic [5:0]       glyph_idx_reg, glyph_idx_next;
    logic [7:0]       scale_reg, scale_next;
    logic [15:0]      fore_reg, fore_next;
    logic [15:0]      back_reg, back_next;
    logic [2:0]       glyph_row_reg, glyph_row_next;
    logic [7:0]       row_rep_reg, row_rep_next;
    logic [2:0]       glyph_col_reg, glyph_col_next;
    logic [7:0]       col_rep_reg, col_rep_next;
    logic [COL_W-1:0] fill_w_reg, fill_w_next;
    logic [COL_W-1:0] fill_col_reg, fill_col_next;
    logic [ROW_W-1:0] fill_row_reg, fill_row_next;

    // Output register.
    logic        out_valid_reg;
    logic [1:0]  kind_reg;
    logic [15:0] col_first_reg, col_last_reg, row_first_reg, row_last_reg;
    logic [15:0] pixel_reg;
    logic        last_reg;

    // Result of the current transfer.
    logic        res_valid;
    logic [1:0]  res_kind;
    logic [15:0] res_col_first, res_col_last, res_row_first, res_row_last;
    logic [15:0] res_pixel;
    logic        res_last;

    // Draw command checks.
    logic [10:0] cell_w, cell_h;
    logic [16:0] cell_x_end, cell_y_end;
    logic        draw_reject;

    assign cell_w     = {1'b0, scale_factor, 2'b00} + {2'b00, scale_factor, 1'b0};
    assign cell_h     = {scale_factor, 3'b000};
    assign cell_x_end = {1'b0, x_pos} + {6'd0, cell_w};
    assign cell_y_end = {1'b0, y_pos} + {6'd0, cell_h};
    assign draw_reject = (scale_factor == 8'd0) || ({1'b0, x_pos} >= SCR_W)
        || ({1'b0, y_pos} >= SCR_H) || (cell_x_end > SCR_W) || (cell_y_end > SCR_H);

    // Fill command checks and clipping.
    logic [16:0]      fill_x_end, fill_y_end;
    logic             fill_reject, clip_w, clip_h;
    logic [16:0]      room_w, room_h;
    logic [COL_W-1:0] clipped_w;
    logic [ROW_W-1:0] clipped_h;

    assign fill_x_end  = {1'b0, x_pos} + {1'b0, rect_width};
    assign fill_y_end  = {1'b0, y_pos} + {1'b0, rect_height};
    assign fill_reject = (rect_width == 16'd0) || (rect_height == 16'd0)
        || ({1'b0, x_pos} >= SCR_W) || ({1'b0, y_pos} >= SCR_H);
    assign clip_w      = fill_x_end > SCR_W;
    assign clip_h      = fill_y_end > SCR_H;
    assign room_w      = SCR_W - {1'b0, x_pos};
    assign room_h      = SCR_H - {1'b0, y_pos};
    // Once the start is on screen, the kept size never exceeds the screen.
    assign clipped_w   = clip_w ? room_w[COL_W-1:0] : rect_width[COL_W-1:0];
    assign clipped_h   = clip_h ? room_h[ROW_W-1:0] : rect_height[ROW_W-1:0];

    // Character pull: dot lookup and end of cell.
    logic [5:0]   font_idx;
    logic [2:0]   font_col;
    logic [7:0]   font_bits;
    logic         dot_lit;
    logic [8:0]   col_rep_inc, row_rep_inc;
    logic         col_wrap, row_wrap, char_last;

    assign font_idx  = (glyph_idx_reg < 6'(sgfpg_pkg::FONT_GLYPHS))
                       ? glyph_idx_reg : sgfpg_pkg::GLYPH_FALLBACK;
    assign font_col  = (glyph_col_reg < 3'(sgfpg_pkg::GLYPH_COLS)) ? glyph_col_reg : 3'd0;
    assign font_bits = sgfpg_pkg::FONT_ROM[font_idx][font_col];
    assign dot_lit   = (glyph_col_reg < 3'(sgfpg_pkg::GLYPH_COLS))
        && (glyph_row_reg < 3'(sgfpg_pkg::GLYPH_ROWS)) && font_bits[glyph_row_reg];

    assign col_rep_inc = {1'b0, col_rep_reg} + 9'd1;
    assign row_rep_inc = {1'b0, row_rep_reg} + 9'd1;
    assign col_wrap    = col_rep_inc >= {1'b0, scale_reg};
    assign row_wrap    = row_rep_inc >= {1'b0, scale_reg};
    assign char_last   = (glyph_row_reg == 3'(sgfpg_pkg::CELL_ROWS - 1))
        && (glyph_col_reg == 3'(sgfpg_pkg::CELL_COLS - 1)) && col_wrap && row_wrap;

    logic fill_last;
    assign fill_last = (fill_col_reg == COL_W'(1)) && (fill_row_reg == ROW_W'(1));

    // Character folding: lower case to upper case, anything outside space to Z to '?'.
    logic [7:0] code_upper, code_kept;
    assign code_upper = (char_code >= sgfpg_pkg::CHAR_LOWER_A
                         && char_code <= sgfpg_pkg::CHAR_LOWER_Z)
                        ? char_code - sgfpg_pkg::CASE_OFFSET : char_code;
    assign code_kept  = (code_upper < sgfpg_pkg::CHAR_SPACE
                         || code_upper > sgfpg_pkg::CHAR_UPPER_Z)
                        ? sgfpg_pkg::CHAR_QUESTION : code_upper;
    logic [7:0] code_offset;
    assign code_offset = code_kept - sgfpg_pkg::CHAR_SPACE;

    // Next state.
    always_comb begin
        mode_next      = mode_reg;
        glyph_idx_next = glyph_idx_reg;
        scale_next     = scale_reg;
        fore_next      = fore_reg;
        back_next      = back_reg;
        glyph_row_next = glyph_row_reg;
        row_rep_next   = row_rep_reg;
        glyph_col_next = glyph_col_reg;
        col_rep_next   = col_rep_reg;
        fill_w_next    = fill_w_reg;
        fill_col_next  = fill_col_reg;
        fill_row_next  = fill_row_reg;
        if (accept) begin
            unique case (op)
                sgfpg_pkg::OP_DRAW: begin
                    mode_next = sgfpg_pkg::MODE_IDLE;
                    if (!draw_reject) begin
                        mode_next      = sgfpg_pkg::MODE_CHAR;
                        glyph_idx_next = code_offset[5:0];
                        scale_next     = scale_factor;
                        fore_next      = fore_color;
                        back_next      = back_color;
                        glyph_row_next = 3'd0;
                        row_rep_next   = 8'd0;
                        glyph_col_next = 3'd0;
                        col_rep_next   = 8'd0;
                    end
                end
                sgfpg_pkg::OP_FILL: begin
                    mode_next = sgfpg_pkg::MODE_IDLE;
                    if (!fill_reject) begin
                        mode_next     = sgfpg_pkg::MODE_FILL;
                        fore_next     = fore_color;
                        fill_w_next   = clipped_w;
                        fill_col_next = clipped_w;
                        fill_row_next = clipped_h;
                    end
                end
                sgfpg_pkg::OP_PULL: begin
                    if (mode_reg == sgfpg_pkg::MODE_FILL) begin
                        if (fill_last) begin
                            mode_next = sgfpg_pkg::MODE_IDLE;
                        end else if (fill_col_reg == COL_W'(1)) begin
                            fill_col_next = fill_w_reg;
                            fill_row_next = fill_row_reg - ROW_W'(1);
                        end else begin
                            fill_col_next = fill_col_reg - COL_W'(1);
                        end
                    end else if (mode_reg == sgfpg_pkg::MODE_CHAR) begin
                        if (char_last) begin
                            mode_next      = sgfpg_pkg::MODE_IDLE;
                            glyph_row_next = 3'd0;
                            row_rep_next   = 8'd0;
                            glyph_col_next = 3'd0;
                            col_rep_next   = 8'd0;
                        end else if (!col_wrap) begin
                            col_rep_next = col_rep_inc[7:0];
                        end else begin
                            col_rep_next = 8'd0;
                            if (glyph_col_reg != 3'(sgfpg_pkg::CELL_COLS - 1)) begin
                                glyph_col_next = glyph_col_reg + 3'd1;
                            end else begin
                                glyph_col_next = 3'd0;
                                if (!row_wrap) begin
                                    row_rep_next = row_rep_inc[7:0];
                                end else begin
                                    row_rep_next   = 8'd0;
                                    glyph_row_next = glyph_row_reg + 3'd1;
                                end
                            end
                        end
                    end
                end
                default: begin
                end
            endcase
        end
    end

    // Result of the transfer.
    always_comb begin
        res_valid     = 1'b0;
        res_kind      = sgfpg_pkg::KIND_REJECT;
        res_col_first = 16'd0;
        res_col_last  = 16'd0;
        res_row_first = 16'd0;
        res_row_last  = 16'd0;
        res_pixel     = 16'd0;
        res_last      = 1'b0;
        unique case (op)
            sgfpg_pkg::OP_DRAW: begin
                res_valid = 1'b1;
                if (!draw_reject) begin
                    res_kind      = sgfpg_pkg::KIND_WINDOW;
                    res_col_first = x_pos;
                    res_col_last  = cell_x_end[15:0] - 16'd1;
                    res_row_first = y_pos;
                    res_row_last  = cell_y_end[15:0] - 16'd1;
                end
            end
            sgfpg_pkg::OP_FILL: begin
                res_valid = 1'b1;
                if (!fill_reject) begin
                    res_kind      = sgfpg_pkg::KIND_WINDOW;
                    res_col_first = x_pos;
                    res_col_last  = clip_w ? 16'(SCREEN_WIDTH - 1)
                                           : fill_x_end[15:0] - 16'd1;
                    res_row_first = y_pos;
                    res_row_last  = clip_h ? 16'(SCREEN_HEIGHT - 1)
                                           : fill_y_end[15:0] - 16'd1;
                end
            end
            sgfpg_pkg::OP_PULL: begin
                if (mode_reg == sgfpg_pkg::MODE_FILL) begin
                    res_valid = 1'b1;
                    res_kind  = sgfpg_pkg::KIND_PIXEL;
                    res_pixel = fore_reg;
                    res_last  = fill_last;
                end else if (mode_reg == sgfpg_pkg::MODE_CHAR) begin
                    res_valid = 1'b1;
                    res_kind  = sgfpg_pkg::KIND_PIXEL;
                    res_pixel = dot_lit ? fore_reg : back_reg;
                    res_last  = char_last;
                end
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            mode_reg      <= sgfpg_pkg::MODE_IDLE;
            glyph_idx_reg <= 6'd0;
            scale_reg     <= 8'd0;
            fore_reg      <= 16'd0;
            back_reg      <= 16'd0;
            glyph_row_reg <= 3'd0;
            row_rep_reg   <= 8'd0;
            glyph_col_reg <= 3'd0;
            col_rep_reg   <= 8'd0;
            fill_w_reg    <= '0;
            fill_col_reg  <= '0;
            fill_row_reg  <= '0;
            out_valid_reg <= 1'b0;
        end else begin
            mode_reg      <= mode_next;
            glyph_idx_reg <= glyph_idx_next;
            scale_reg     <= scale_next;
            fore_reg      <= fore_next;
            back_reg      <= back_next;
            glyph_row_reg <= glyph_row_next;
            row_rep_reg   <= row_rep_next;
            glyph_col_reg <= glyph_col_next;
            col_rep_reg   <= col_rep_next;
            fill_w_reg    <= fill_w_next;
            fill_col_reg  <= fill_col_next;
            fill_row_reg  <= fill_row_next;
            if (s_tready) begin
                out_valid_reg <= accept && res_valid;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (accept) begin
            kind_reg      <= res_kind;
            col_first_reg <= res_col_first;
            col_last_reg  <= res_col_last;
            row_first_reg <= res_row_first;
            row_last_reg  <= res_row_last;
            pixel_reg     <= res_pixel;
            last_reg      <= res_last;
        end
    end

    assign s_tready = !out_valid_reg || m_tready;
    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {pixel_reg, row_last_reg, row_first_reg, col_last_reg, col_first_reg};
    assign m_tuser  = kind_reg;
    assign m_tlast  = last_reg;

    // A rejected command carries an all-zero window and no end marker.
    `SGFPG_ASSERT_SAME(a_reject_clean, aclk, aresetn,
        m_tvalid && (m_tuser == sgfpg_pkg::KIND_REJECT),
        (m_tdata == 80'd0) && !m_tlast, "rejected result carries data")

    // Only pixel results can end a job.
    `SGFPG_ASSERT_SAME(a_last_is_pixel, aclk, aresetn, m_tvalid && m_tlast,
        m_tuser == sgfpg_pkg::KIND_PIXEL, "end marker on a non-pixel result")

    // A running character job always holds a nonzero scale.
    `SGFPG_ASSERT_SAME(a_char_scale, aclk, aresetn, mode_reg == sgfpg_pkg::MODE_CHAR,
        scale_reg != 8'd0, "character job with zero scale")

    // A running fill job never has an exhausted counter.
    `SGFPG_ASSERT_SAME(a_fill_counts, aclk, aresetn, mode_reg == sgfpg_pkg::MODE_FILL,
        (fill_col_reg != '0) && (fill_row_reg != '0), "fill job with empty counter")

    // A draw command never leaves a fill job running.
    `SGFPG_ASSERT_NEXT(a_draw_ends_fill, aclk, aresetn,
        accept && (op == sgfpg_pkg::OP_DRAW),
        mode_reg != sgfpg_pkg::MODE_FILL, "fill job survived a draw command")

endmodule

`default_nettype wire

/* verif/tb_top.sv */
// ----------------------------------------------------------------------------
// Testbench for the scaled glyph and fill pixel generator
// Drives draw, fill and pull commands on the input stream. A cycle-free model
// of the block predicts every window, reject and pixel, and each result
// transfer is compared field by field against the oldest prediction. Both
// stream sides idle and stall at random outside the steady run.
// ----------------------------------------------------------------------------
module tb_top;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int unsigned SCREEN_W       = 320;
    localparam int unsigned SCREEN_H       = 240;
    localparam int unsigned LIT_COLS       = 5;
    localparam int unsigned LIT_ROWS       = 7;
    localparam int unsigned DOT_COLS       = 6;
    localparam int unsigned DOT_ROWS       = 8;
    localparam int unsigned MAX_SCALE_FIT  = 30;
    localparam int unsigned WATCHDOG_LIMIT = 2000;
    localparam int unsigned DRAIN_CYCLES   = 20;
    localparam int unsigned TARGET_ITEMS   = 1100;
    localparam int unsigned STEADY_ITEMS   = 250;
    localparam logic [1:0]  OP_UNUSED      = 2'd3;

    // Glyph columns from space to Z, leftmost column in the top byte.
    // Bit 0 of each column byte is the top dot.
    localparam logic [39:0] GLYPH_FONT [59] = '{
        40'h0000000000, 40'h00005F0000, 40'h0007000700, 40'h147F147F14,
        40'h242A7F2A12, 40'h2313086462, 40'h3649552250, 40'h0005030000,
        40'h001C224100, 40'h0041221C00, 40'h14083E0814, 40'h08083E0808,
        40'h0050300000, 40'h0808080808, 40'h0060600000, 40'h2010080402,
        40'h3E5149453E, 40'h00427F4000, 40'h4261514946, 40'h2141454B31,
        40'h1814127F10, 40'h2745454539, 40'h3C4A494930, 40'h0171090503,
        40'h3649494936, 40'h064949291E, 40'h0036360000, 40'h0056360000,
        40'h0814224100, 40'h1414141414, 40'h0041221408, 40'h0201510906,
        40'h324979413E, 40'h7E1111117E, 40'h7F49494936, 40'h3E41414122,
        40'h7F4141221C, 40'h7F49494941, 40'h7F09090901, 40'h3E4149497A,
        40'h7F0808087F, 40'h00417F4100, 40'h2040413F01, 40'h7F08142241,
        40'h7F40404040, 40'h7F020C027F, 40'h7F0408107F, 40'h3E4141413E,
        40'h7F09090906, 40'h3E4151215E, 40'h7F09192946, 40'h4649494931,
        40'h01017F0101, 40'h3F4040403F, 40'h1F2040201F, 40'h3F4038403F,
        40'h6314081463, 40'h0708700807, 40'h6151494543
    };

    typedef struct packed {
        logic [15:0] back_color;
        logic [15:0] fore_color;
        logic [7:0]  scale;
        logic [7:0]  code;
        logic [15:0] height;
        logic [15:0] width;
        logic [15:0] y;
        logic [15:0] x;
    } command_t;

    typedef struct packed {
        logic [15:0] pixel_color;
        logic [15:0] row_last;
        logic [15:0] row_first;
        logic [15:0] col_last;
        logic [15:0] col_first;
    } window_bus_t;

    typedef struct packed {
        logic [1:0]  kind;
        logic        last;
        window_bus_t bus;
    } reply_t;

    logic         aclk     = 1'b0;
    logic         aresetn  = 1'b0;
    logic         s_tvalid = 1'b0;
    logic         s_tready;
    logic [111:0] s_tdata  = '0;
    logic [1:0]   s_tuser  = '0;
    logic         m_tvalid;
    logic         m_tready = 1'b0;
    logic [79:0]  m_tdata;
    logic [1:0]   m_tuser;
    logic         m_tlast;

    // Model state of the generator.
    sgfpg_pkg::job_mode_t job_state = sgfpg_pkg::MODE_IDLE;
    logic [5:0]   glyph_sel  = '0;
    int unsigned  held_scale = 0;
    logic [15:0]  held_fore  = '0;
    logic [15:0]  held_back  = '0;
    int unsigned  dot_row    = 0;
    int unsigned  row_rep    = 0;
    int unsigned  dot_col    = 0;
    int unsigned  col_rep    = 0;
    int unsigned  fill_left  = 0;

    reply_t       pixel_stream_q [$];
    int unsigned  items_sent     = 0;
    int unsigned  mismatch_count = 0;
    int unsigned  quiet_cycles   = 0;
    bit           steady_run     = 1'b0;

    scaled_glyph_and_fill_pixel_generator #(
        .SCREEN_WIDTH  (SCREEN_W),
        .SCREEN_HEIGHT (SCREEN_H)
    ) dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .m_tlast  (m_tlast)
    );

    always #5 aclk = ~aclk;

    function automatic logic [5:0] glyph_of(input logic [7:0] code);
        logic [7:0] folded;
        folded = code;
        if (folded >= "a" && folded <= "z") begin
            folded = folded - ("a" - "A");
        end
        if (folded < " " || folded > "Z") begin
            folded = "?";
        end
        return 6'(folded - " ");
    endfunction

    // Advances the model by one accepted command and returns 1 when the block
    // answers it.
    function automatic bit compute_pixel_reply(input logic [1:0] op, input command_t c,
                                               output reply_t r);
        int unsigned span_w;
        int unsigned span_h;
        int unsigned w;
        int unsigned h;
        bit          lit;
        bit          final_dot;
        r      = '0;
        span_w = DOT_COLS * c.scale;
        span_h = DOT_ROWS * c.scale;
        case (op)
            sgfpg_pkg::OP_DRAW: begin
                job_state = sgfpg_pkg::MODE_IDLE;
                r.kind    = sgfpg_pkg::KIND_REJECT;
                if (c.scale != 0 && c.x < SCREEN_W && c.y < SCREEN_H &&
                    c.x + span_w <= SCREEN_W && c.y + span_h <= SCREEN_H) begin
                    job_state  = sgfpg_pkg::MODE_CHAR;
                    glyph_sel  = glyph_of(c.code);
                    held_scale = c.scale;
                    held_fore  = c.fore_color;
                    held_back  = c.back_color;
                    dot_row    = 0;
                    row_rep    = 0;
                    dot_col    = 0;
                    col_rep    = 0;
                    r.kind     = sgfpg_pkg::KIND_WINDOW;
                    r.bus.col_first = c.x;
                    r.bus.col_last  = 16'(c.x + span_w - 1);
                    r.bus.row_first = c.y;
                    r.bus.row_last  = 16'(c.y + span_h - 1);
                end
                return 1'b1;
            end
            sgfpg_pkg::OP_FILL: begin
                job_state = sgfpg_pkg::MODE_IDLE;
                r.kind    = sgfpg_pkg::KIND_REJECT;
                if (c.width != 0 && c.height != 0 && c.x < SCREEN_W && c.y < SCREEN_H) begin
                    w = (c.x + c.width > SCREEN_W) ? SCREEN_W - c.x : c.width;
                    h = (c.y + c.height > SCREEN_H) ? SCREEN_H - c.y : c.height;
                    job_state = sgfpg_pkg::MODE_FILL;
                    held_fore = c.fore_color;
                    fill_left = w * h;
                    r.kind    = sgfpg_pkg::KIND_WINDOW;
                    r.bus.col_first = c.x;
                    r.bus.col_last  = 16'(c.x + w - 1);
                    r.bus.row_first = c.y;
                    r.bus.row_last  = 16'(c.y + h - 1);
                end
                return 1'b1;
            end
            sgfpg_pkg::OP_PULL: begin
                if (job_state == sgfpg_pkg::MODE_FILL) begin
                    r.kind = sgfpg_pkg::KIND_PIXEL;
                    r.bus.pixel_color = held_fore;
                    r.last = (fill_left <= 1);
                    if (r.last) begin
                        fill_left = 0;
                        job_state = sgfpg_pkg::MODE_IDLE;
                    end else begin
                        fill_left--;
                    end
                    return 1'b1;
                end
                if (job_state == sgfpg_pkg::MODE_CHAR) begin
                    lit = 1'b0;
                    if (dot_col < LIT_COLS && dot_row < LIT_ROWS) begin
                        lit = GLYPH_FONT[glyph_sel][32 - 8 * dot_col + dot_row];
                    end
                    final_dot = (dot_row == DOT_ROWS - 1) && (dot_col == DOT_COLS - 1) &&
                                (row_rep + 1 >= held_scale) && (col_rep + 1 >= held_scale);
                    r.kind = sgfpg_pkg::KIND_PIXEL;
                    r.bus.pixel_color = lit ? held_fore : held_back;
                    r.last = final_dot;
                    col_rep++;
                    if (col_rep >= held_scale) begin
                        col_rep = 0;
                        dot_col++;
                        if (dot_col >= DOT_COLS) begin
                            dot_col = 0;
                            row_rep++;
                            if (row_rep >= held_scale) begin
                                row_rep = 0;
                                dot_row++;
                            end
                        end
                    end
                    if (final_dot) begin
                        job_state = sgfpg_pkg::MODE_IDLE;
                        dot_row   = 0;
                        row_rep   = 0;
                        dot_col   = 0;
                        col_rep   = 0;
                    end
                    return 1'b1;
                end
                return 1'b0;
            end
            default: return 1'b0;
        endcase
    endfunction

    function automatic command_t random_payload();
        logic [127:0] raw;
        raw = {$urandom(), $urandom(), $urandom(), $urandom()};
        return raw[111:0];
    endfunction

    function automatic command_t char_command(input int unsigned x, input int unsigned y,
                                              input int unsigned code,
                                              input int unsigned scale);
        command_t c;
        c       = random_payload();
        c.x     = 16'(x);
        c.y     = 16'(y);
        c.code  = 8'(code);
        c.scale = 8'(scale);
        return c;
    endfunction

    function automatic command_t rect_command(input int unsigned x, input int unsigned y,
                                              input int unsigned w, input int unsigned h);
        command_t c;
        c        = random_payload();
        c.x      = 16'(x);
        c.y      = 16'(y);
        c.width  = 16'(w);
        c.height = 16'(h);
        return c;
    endfunction

    // One command transfer; the model is advanced at the edge that accepts it.
    task automatic send_command(input logic [1:0] op, input command_t c);
        reply_t r;
        if (!steady_run) begin
            while ($urandom_range(0, 99) < 33) begin
                s_tvalid <= 1'b0;
                @(posedge aclk);
            end
        end
        s_tvalid <= 1'b1;
        s_tuser  <= op;
        s_tdata  <= c;
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        items_sent++;
        if (compute_pixel_reply(op, c, r)) begin
            pixel_stream_q.push_back(r);
        end
    endtask

    task automatic pull_pixels(input int unsigned count);
        repeat (count) send_command(sgfpg_pkg::OP_PULL, random_payload());
    endtask

    task automatic drain_job();
        while (job_state != sgfpg_pkg::MODE_IDLE) begin
            send_command(sgfpg_pkg::OP_PULL, random_payload());
        end
    endtask

    task automatic test_glyph_draws();
        send_command(sgfpg_pkg::OP_DRAW, char_command(0, 0, "A", 1));
        drain_job();
        pull_pixels(1);
        // Lower case folds to upper case; the cell touches the bottom right corner.
        send_command(sgfpg_pkg::OP_DRAW,
                     char_command(SCREEN_W - DOT_COLS, SCREEN_H - DOT_ROWS, "g", 1));
        drain_job();
        send_command(sgfpg_pkg::OP_DRAW, char_command(100, 50, 8'h00, 2));
        drain_job();
        send_command(sgfpg_pkg::OP_DRAW, char_command(7, 9, 8'hFF, 1));
        pull_pixels(10);
        send_command(sgfpg_pkg::OP_DRAW, char_command(20, 30, "[", 1));
        drain_job();
        // The largest scale that fits; left running so the next command aborts it.
        send_command(sgfpg_pkg::OP_DRAW, char_command(0, 0, "~", MAX_SCALE_FIT));
        pull_pixels(70);
    endtask

    task automatic test_draw_rejects();
        send_command(sgfpg_pkg::OP_DRAW, char_command(0, 0, "B", 0));
        send_command(sgfpg_pkg::OP_DRAW, char_command(SCREEN_W - DOT_COLS + 1, 0, "B", 1));
        send_command(sgfpg_pkg::OP_DRAW, char_command(0, SCREEN_H - DOT_ROWS + 1, "B", 1));
        send_command(sgfpg_pkg::OP_DRAW, char_command(SCREEN_W, 0, "B", 1));
        send_command(sgfpg_pkg::OP_DRAW, char_command(0, SCREEN_H, "B", 1));
        send_command(sgfpg_pkg::OP_DRAW, char_command(16'hFFFF, 16'hFFFF, "B", 8'hFF));
        send_command(sgfpg_pkg::OP_DRAW, char_command(0, 0, "B", MAX_SCALE_FIT + 1));
        pull_pixels(1);
        // A rejected draw still ends the job that was running.
        send_command(sgfpg_pkg::OP_DRAW, char_command(40, 40, "C", 1));
        pull_pixels(3);
        send_command(sgfpg_pkg::OP_DRAW, char_command(0, 0, "C", 0));
        pull_pixels(1);
    endtask

    task automatic test_rect_fills();
        send_command(sgfpg_pkg::OP_FILL, rect_command(0, 0, 1, 1));
        drain_job();
        pull_pixels(1);
        send_command(sgfpg_pkg::OP_FILL,
                     rect_command(SCREEN_W - 2, SCREEN_H - 2, 16'hFFFF, 16'hFFFF));
        drain_job();
        send_command(sgfpg_pkg::OP_FILL, rect_command(5, 5, 0, 3));
        send_command(sgfpg_pkg::OP_FILL, rect_command(5, 5, 3, 0));
        send_command(sgfpg_pkg::OP_FILL, rect_command(SCREEN_W, 0, 4, 4));
        send_command(sgfpg_pkg::OP_FILL, rect_command(0, SCREEN_H, 4, 4));
        send_command(sgfpg_pkg::OP_FILL, rect_command(0, 0, SCREEN_W, SCREEN_H));
        pull_pixels(5);
        send_command(OP_UNUSED, random_payload());
        pull_pixels(2);
        send_command(sgfpg_pkg::OP_DRAW, char_command(50, 60, "Z", 1));
        drain_job();
    endtask

    task automatic test_ignored_codes();
        repeat (3) send_command(OP_UNUSED, random_payload());
        pull_pixels(2);
    endtask

    task automatic random_glyph_job();
        int unsigned pick;
        int unsigned scale;
        pick  = $urandom_range(0, 99);
        scale = (pick < 60) ? 1 : (pick < 85) ? 2 : $urandom_range(3, MAX_SCALE_FIT);
        send_command(sgfpg_pkg::OP_DRAW,
                     char_command($urandom_range(0, SCREEN_W - DOT_COLS * scale),
                                  $urandom_range(0, SCREEN_H - DOT_ROWS * scale),
                                  $urandom_range(0, 255), scale));
        if (scale <= 2 && $urandom_range(0, 9) < 7) begin
            drain_job();
        end else begin
            pull_pixels($urandom_range(0, 60));
        end
    endtask

    task automatic random_fill_job();
        if ($urandom_range(0, 4) == 0) begin
            // Near the corner so that clipping keeps the job short.
            send_command(sgfpg_pkg::OP_FILL,
                         rect_command($urandom_range(SCREEN_W - 20, SCREEN_W - 1),
                                      $urandom_range(SCREEN_H - 15, SCREEN_H - 1),
                                      $urandom_range(1, 16'hFFFF),
                                      $urandom_range(1, 16'hFFFF)));
        end else begin
            send_command(sgfpg_pkg::OP_FILL,
                         rect_command($urandom_range(0, SCREEN_W - 1),
                                      $urandom_range(0, SCREEN_H - 1),
                                      $urandom_range(1, 12), $urandom_range(1, 12)));
        end
        if ($urandom_range(0, 3) != 0) begin
            drain_job();
        end else begin
            pull_pixels($urandom_range(0, 20));
        end
    endtask

    task automatic test_random_jobs(input int unsigned target);
        int unsigned pick;
        while (items_sent < target) begin
            pick = $urandom_range(0, 99);
            if (pick < 30) begin
                send_command(2'($urandom_range(0, 3)), random_payload());
            end else if (pick < 65) begin
                random_glyph_job();
            end else begin
                random_fill_job();
            end
            if ($urandom_range(0, 3) == 0) pull_pixels(1);
        end
    endtask

    always @(posedge aclk) begin
        m_tready <= steady_run || ($urandom_range(0, 99) >= 33);
    end

    function automatic void check_field(input string name, input logic [15:0] want,
                                        input logic [15:0] got);
        if (got !== want) begin
            $display("%0t: %s mismatch, expected %h, actual %h", $time, name, want, got);
            mismatch_count++;
        end
    endfunction

    always @(posedge aclk) begin : check_results
        reply_t      want;
        window_bus_t got;
        if (aresetn && m_tvalid && m_tready) begin
            got = m_tdata;
            if (pixel_stream_q.size() == 0) begin
                $display("%0t: unexpected result, expected none, actual kind %0d tdata %h",
                         $time, m_tuser, m_tdata);
                mismatch_count++;
            end else begin
                want = pixel_stream_q.pop_front();
                check_field("kind", want.kind, m_tuser);
                check_field("col_first", want.bus.col_first, got.col_first);
                check_field("col_last", want.bus.col_last, got.col_last);
                check_field("row_first", want.bus.row_first, got.row_first);
                check_field("row_last", want.bus.row_last, got.row_last);
                check_field("pixel_color", want.bus.pixel_color, got.pixel_color);
                check_field("last", want.last, m_tlast);
            end
        end
    end

    always @(posedge aclk) begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
            quiet_cycles = 0;
        end else begin
            quiet_cycles++;
            if (quiet_cycles >= WATCHDOG_LIMIT) begin
                $display("%0t: watchdog, no transfer for %0d cycles", $time, quiet_cycles);
                $display("TEST FAILED");
                $finish;
            end
        end
    end

    initial begin
        repeat (6) @(posedge aclk);
        aresetn <= 1'b1;
        test_glyph_draws();
        test_draw_rejects();
        test_rect_fills();
        test_ignored_codes();
        steady_run <= 1'b1;
        test_random_jobs(items_sent + STEADY_ITEMS);
        steady_run <= 1'b0;
        test_random_jobs(TARGET_ITEMS);
        s_tvalid <= 1'b0;
        while (pixel_stream_q.size() != 0) @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);
        if (mismatch_count == 0) begin
            $display("TEST PASSED");
        end else begin
            $display("TEST FAILED");
        end
        $finish;
    end

endmodule

/* scaled_glyph_and_fill_pixel_generator.f */
+incdir+sv
sv/sgfpg_pkg.sv
sv/scaled_glyph_and_fill_pixel_generator.sv
verif/tb_top.sv
